// ----- rtl/core/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, quiet while reset is held
`define SPL_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("spl assertion failed");

// clocked assertion that also runs through reset
`define SPL_ASSERT_NR(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("spl assertion failed during reset");

`endif

// ----- rtl/core/spl_pkg.sv -----
// types, widths and constants of the servo pulse slew limiter
package spl_pkg;

  localparam int NUM_SERVOS_DEF = 8;

  localparam int SERVO_IDX_W = 3;
  localparam int POS_W       = 8;
  localparam int SPEED_W     = 8;
  localparam int GAIN_W      = 8;
  localparam int PULSE_W     = 16;
  localparam int SLEW_W      = 16;
  localparam int FLAGS_W     = 8;

  localparam int SUM_W    = POS_W + 1;
  localparam int TERM_W   = GAIN_W + SUM_W;
  localparam int GS_W     = GAIN_W + SPEED_W;
  localparam int STEP_W   = 11;
  localparam int TARGET_W = TERM_W + 1;
  localparam int DIFF_W   = TARGET_W + 1;

  // divide by the speed divisor via reciprocal multiply
  localparam int SPEED_DIVISOR = 50;
  localparam int RECIP_SHIFT   = 22;
  localparam int RECIP_W       = 17;
  localparam logic [RECIP_W-1:0] RECIP_MULT =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + SPEED_DIVISOR - 1) / SPEED_DIVISOR);
  localparam int RECIP_PROD_W  = GS_W + RECIP_W;

  localparam logic [PULSE_W-1:0] NEUTRAL_RESET = 16'd30000;
  localparam logic [GAIN_W-1:0]  GAIN_RESET    = 8'd142;
  localparam logic [SLEW_W-1:0]  SLEW_RESET    = 16'd1000;
  localparam logic [FLAGS_W-1:0] DIR_RESET     = 8'd0;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_NEUTRAL = 2'd0,
    CFG_GAIN    = 2'd1,
    CFG_SLEW    = 2'd2,
    CFG_DIR     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [SERVO_IDX_W-1:0]   servo_index;
    logic signed [POS_W-1:0]  target_position;
    logic [SPEED_W-1:0]       servo_speed;
    logic signed [POS_W-1:0]  position_offset;
  } in_word_t;

  typedef struct packed {
    logic [PULSE_W-1:0] pulse_width;
    logic               locked;
    logic [FLAGS_W-1:0] lock_flags;
  } out_word_t;

  typedef struct packed {
    logic [PULSE_W-1:0] neutral_count;
    logic [GAIN_W-1:0]  angle_gain;
    logic [SLEW_W-1:0]  max_slew;
    logic [FLAGS_W-1:0] direction_mask;
  } cfg_t;

  typedef struct packed {
    logic [SERVO_IDX_W-1:0]     servo_index;
    logic signed [TARGET_W-1:0] target;
    logic [STEP_W-1:0]          step;
  } calc_t;

endpackage

// ----- rtl/core/spl_cfg.sv -----
// configuration register file
module spl_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [spl_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [spl_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output spl_pkg::cfg_t                    cfg
);
  import spl_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.neutral_count  <= NEUTRAL_RESET;
      cfg_r.angle_gain     <= GAIN_RESET;
      cfg_r.max_slew       <= SLEW_RESET;
      cfg_r.direction_mask <= DIR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_NEUTRAL: cfg_r.neutral_count  <= cfg_wdata[PULSE_W-1:0];
        CFG_GAIN:    cfg_r.angle_gain     <= cfg_wdata[GAIN_W-1:0];
        CFG_SLEW:    cfg_r.max_slew       <= cfg_wdata[SLEW_W-1:0];
        CFG_DIR:     cfg_r.direction_mask <= cfg_wdata[FLAGS_W-1:0];
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/core/spl_calc.sv -----
// two pipeline stages: gain products, then slew step and target count
module spl_calc (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  spl_pkg::in_word_t up_data,
  input  spl_pkg::cfg_t     cfg,
  output logic              dn_valid,
  input  logic              dn_ready,
  output spl_pkg::calc_t    dn_data
);
  import spl_pkg::*;

  // product stage
  logic                       a_v_r;
  logic [SERVO_IDX_W-1:0]     a_idx_r;
  logic                       a_dir_r;
  logic signed [TERM_W-1:0]   a_term_r;
  logic [GS_W-1:0]            a_gs_r;
  logic signed [SUM_W-1:0]    angle_sum;
  logic signed [TERM_W-1:0]   term_nxt;
  logic [GS_W-1:0]            gs_nxt;
  logic                       a_ready;

  // step and target stage
  logic                       b_v_r;
  calc_t                      b_q_r;
  logic [RECIP_PROD_W-1:0]    recip_prod;
  logic [STEP_W-1:0]          quot;
  logic [STEP_W-1:0]          step_nxt;
  logic signed [TARGET_W-1:0] term_ext;
  logic signed [TARGET_W-1:0] target_nxt;
  logic                       b_ready;

  assign a_ready  = !a_v_r || b_ready;
  assign up_ready = a_ready;

  assign angle_sum = SUM_W'($signed(up_data.target_position)) +
                     SUM_W'($signed(up_data.position_offset));
  assign term_nxt  = TERM_W'($signed({1'b0, cfg.angle_gain})) * TERM_W'(angle_sum);
  assign gs_nxt    = GS_W'(cfg.angle_gain) * GS_W'(up_data.servo_speed);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (a_ready) begin
      a_v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && a_ready) begin
      a_idx_r  <= up_data.servo_index;
      a_dir_r  <= cfg.direction_mask[up_data.servo_index];
      a_term_r <= term_nxt;
      a_gs_r   <= gs_nxt;
    end
  end

  assign b_ready = !b_v_r || dn_ready;

  // gain * speed / 50, exact over the whole 16-bit product range
  assign recip_prod = RECIP_PROD_W'(a_gs_r) * RECIP_PROD_W'(RECIP_MULT);
  assign quot       = recip_prod[RECIP_SHIFT +: STEP_W];
  assign step_nxt   = (SLEW_W'(quot) > cfg.max_slew) ? cfg.max_slew[STEP_W-1:0] : quot;

  assign term_ext   = a_dir_r ? -TARGET_W'(a_term_r) : TARGET_W'(a_term_r);
  assign target_nxt = $signed({{(TARGET_W-PULSE_W){1'b0}}, cfg.neutral_count}) + term_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (b_ready) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_v_r && b_ready) begin
      b_q_r.servo_index <= a_idx_r;
      b_q_r.target      <= target_nxt;
      b_q_r.step        <= step_nxt;
    end
  end

  assign dn_valid = b_v_r;
  assign dn_data  = b_q_r;

endmodule

// ----- rtl/core/spl_track.sv -----
// per-servo pulse state, lock flags and result register
module spl_track #(
  parameter int NUM_SERVOS = spl_pkg::NUM_SERVOS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  spl_pkg::calc_t     up_data,
  output logic               out_valid,
  input  logic               out_stall,
  output spl_pkg::out_word_t out_data
);
  import spl_pkg::*;

  localparam int SLOT_W = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;

  logic [PULSE_W-1:0]       pulse_r [NUM_SERVOS];
  logic [FLAGS_W-1:0]       lock_r;
  logic                     out_v_r;
  out_word_t                out_q_r;

  logic                     accept;
  logic                     in_range;
  logic [SLOT_W-1:0]        slot;
  logic [PULSE_W-1:0]       cur;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] step_s;
  logic [PULSE_W-1:0]       pulse_nxt;
  logic                     lock_nxt;
  logic [FLAGS_W-1:0]       bit_mask;
  logic [FLAGS_W-1:0]       flags_nxt;

  assign up_ready = !out_v_r || !out_stall;
  assign accept   = up_valid && up_ready;

  assign in_range = (32'(up_data.servo_index) < NUM_SERVOS);
  assign slot     = up_data.servo_index[SLOT_W-1:0];
  assign cur      = in_range ? pulse_r[slot] : '0;

  assign diff   = DIFF_W'(up_data.target) - $signed({{(DIFF_W-PULSE_W){1'b0}}, cur});
  assign step_s = $signed({{(DIFF_W-STEP_W){1'b0}}, up_data.step});

  always_comb begin
    priority if (diff > step_s) begin
      pulse_nxt = cur + PULSE_W'(up_data.step);
      lock_nxt  = 1'b0;
    end else if (diff < -step_s) begin
      pulse_nxt = cur - PULSE_W'(up_data.step);
      lock_nxt  = 1'b0;
    end else begin
      pulse_nxt = up_data.target[PULSE_W-1:0];
      lock_nxt  = 1'b1;
    end
  end

  assign bit_mask  = FLAGS_W'(1) << up_data.servo_index;
  assign flags_nxt = lock_nxt ? (lock_r | bit_mask) : (lock_r & ~bit_mask);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      lock_r  <= '0;
      for (int i = 0; i < NUM_SERVOS; i++) begin
        pulse_r[i] <= NEUTRAL_RESET;
      end
    end else begin
      if (up_ready) begin
        out_v_r <= up_valid;
      end
      if (accept && in_range) begin
        pulse_r[slot] <= pulse_nxt;
        lock_r        <= flags_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (in_range) begin
        out_q_r.pulse_width <= pulse_nxt;
        out_q_r.locked      <= lock_nxt;
        out_q_r.lock_flags  <= flags_nxt;
      end else begin
        // unknown servo: no state change, report current flags
        out_q_r.pulse_width <= '0;
        out_q_r.locked      <= 1'b0;
        out_q_r.lock_flags  <= lock_r;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_q_r;

endmodule

// ----- rtl/core/servo_pulse_slew_limiter.sv -----
// Servo pulse slew limiter: target count, speed-limited step, per-servo lock flags.
// Pipeline: an accepted word passes the input register, product register,
// step/target register and result register in turn.
// Throughput: one word per cycle; each stage holds only while the next one is full.
// Reset (synchronous, rst_n low): every pulse count to 30000, lock flags cleared,
// configuration registers to their defaults, pipeline emptied.
module servo_pulse_slew_limiter #(
  parameter int NUM_SERVOS = spl_pkg::NUM_SERVOS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  spl_pkg::in_word_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output spl_pkg::out_word_t              out_data,
  input  logic                            cfg_we,
  input  logic [spl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [spl_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import spl_pkg::*;

  cfg_t     cfg;
  logic     in_v_r;
  in_word_t in_q_r;
  logic     in_ready;
  logic     calc_ready;
  logic     calc_valid;
  calc_t    calc_data;
  logic     track_ready;

  assign in_ready = !in_v_r || calc_ready;
  assign in_stall = !in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q_r <= in_data;
    end
  end

  spl_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  spl_calc u_calc (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_v_r),
    .up_ready (calc_ready),
    .up_data  (in_q_r),
    .cfg      (cfg),
    .dn_valid (calc_valid),
    .dn_ready (track_ready),
    .dn_data  (calc_data)
  );

  spl_track #(
    .NUM_SERVOS (NUM_SERVOS)
  ) u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (calc_valid),
    .up_ready  (track_ready),
    .up_data   (calc_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/core/spl_check.sv -----
// port-level checker for the slew limiter, bound to the top level
`include "assert_macros.svh"

module spl_check (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input spl_pkg::in_word_t               in_data,
  input logic                            out_valid,
  input logic                            out_stall,
  input spl_pkg::out_word_t              out_data
);
  import spl_pkg::*;

  // a held input word keeps its value
  `SPL_ASSERT(a_in_hold, in_valid && in_stall |=> in_valid && $stable(in_data))

  // a held result word keeps its value
  `SPL_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data))

  // a locked servo must show up in the flags word
  `SPL_ASSERT(a_lock_in_flags, out_valid && out_data.locked |-> out_data.lock_flags != '0)

  // with nothing waiting at the output the pipeline always has room
  `SPL_ASSERT(a_room_when_empty, !out_valid |-> !in_stall)

  // reset empties the result register
  `SPL_ASSERT_NR(a_reset_idle, !rst_n |=> !out_valid)

endmodule

bind servo_pulse_slew_limiter spl_check u_spl_check (.*);

// ----- sim/tb.sv -----
// self-checking testbench for the servo pulse slew limiter
`timescale 1ns / 100ps

module tb;
  import spl_pkg::*;

  localparam int NUM_SERVOS     = NUM_SERVOS_DEF;
  localparam int SPEED_DIV      = 50;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_WORDS    = 212;
  localparam int PRINT_LIMIT    = 40;
  localparam int IN_W           = $bits(in_word_t);

  // servo state and register file as the block holds them, one expected word per command
  class servo_pulse_model;
    cfg_t               regs;
    logic [PULSE_W-1:0] pulse [NUM_SERVOS];
    logic [FLAGS_W-1:0] lock_bits;
    out_word_t          expected_words [$];

    function new();
      regs = cfg_t'{16'd30000, 8'd142, 16'd1000, 8'h00};
      foreach (pulse[i]) pulse[i] = 16'd30000;
      lock_bits = '0;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void note_command(in_word_t w);
      int        idx, term, goal, step, cur, diff, nxt;
      bit        hit;
      out_word_t want;
      idx = int'(w.servo_index);
      want = '0;
      if (idx >= NUM_SERVOS) begin
        want.lock_flags = lock_bits;
      end else begin
        term = int'(regs.angle_gain) *
               (int'($signed(w.target_position)) + int'($signed(w.position_offset)));
        if (regs.direction_mask[idx]) term = -term;
        goal = int'(regs.neutral_count) + term;
        step = int'(regs.angle_gain) * int'(w.servo_speed) / SPEED_DIV;
        if (step > int'(regs.max_slew)) step = int'(regs.max_slew);
        cur  = int'(pulse[idx]);
        diff = goal - cur;
        if (diff > step) begin
          nxt = cur + step;
          hit = 1'b0;
        end else if (diff < -step) begin
          nxt = cur - step;
          hit = 1'b0;
        end else begin
          nxt = goal;
          hit = 1'b1;
        end
        // stored count wraps to 16 bits
        pulse[idx]     = nxt[15:0];
        lock_bits[idx] = hit;
        want.pulse_width = pulse[idx];
        want.locked      = hit;
        want.lock_flags  = lock_bits;
      end
      expected_words.push_back(want);
    endfunction

    function string check_pulse(out_word_t got);
      out_word_t want;
      string     msg;
      if (expected_words.size() == 0)
        return $sformatf("word with none expected: pulse_width %0d locked %0b flags %h",
                         got.pulse_width, got.locked, got.lock_flags);
      want = expected_words.pop_front();
      msg = "";
      if (got.pulse_width !== want.pulse_width)
        msg = {msg, $sformatf(" pulse_width %0d want %0d", got.pulse_width, want.pulse_width)};
      if (got.locked !== want.locked)
        msg = {msg, $sformatf(" locked %0b want %0b", got.locked, want.locked)};
      if (got.lock_flags !== want.lock_flags)
        msg = {msg, $sformatf(" lock_flags %h want %h", got.lock_flags, want.lock_flags)};
      return msg;
    endfunction
  endclass

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  in_word_t               in_data   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_word_t              out_data;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  servo_pulse_model model = new();
  int fail_count  = 0;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int quiet_count = 0;

  servo_pulse_slew_limiter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (fail_count < PRINT_LIMIT) $display("tb: mismatch at %0t:%s", $realtime, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_stall <= (int'($urandom_range(99)) < stall_pct);
  end

  always @(posedge clk) begin
    string msg;
    if (rst_n && out_valid && !out_stall) begin
      msg = model.check_pulse(out_data);
      if (msg != "") report_mismatch(msg);
    end
  end

  // ends the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_count <= 0;
    end else if (quiet_count >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  function automatic in_word_t mk(input logic [2:0] idx, input logic signed [7:0] pos,
                                  input logic [7:0] spd, input logic signed [7:0] off);
    in_word_t w;
    w.servo_index     = idx;
    w.target_position = pos;
    w.servo_speed     = spd;
    w.position_offset = off;
    return w;
  endfunction

  function automatic logic signed [7:0] pick_angle();
    case ($urandom_range(5))
      0: return -8'sd128;
      1: return 8'sd127;
      2: return 8'sd0;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] pick_speed();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      2, 3: return 8'($urandom_range(255));
      default: return 8'($urandom_range(180, 255));
    endcase
  endfunction

  task automatic send_word(input in_word_t w);
    if (idle_pct != 0 && int'($urandom_range(99)) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (int'($urandom_range(99)) < idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    model.note_command(w);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (model.pending() != 0);
  endtask

  task automatic put_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  // drains the pipeline itself before writing the registers
  task automatic write_config(input cfg_t c);
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    put_reg(CFG_NEUTRAL, c.neutral_count);
    put_reg(CFG_GAIN, CFG_DATA_W'(c.angle_gain));
    put_reg(CFG_SLEW, c.max_slew);
    put_reg(CFG_DIR, CFG_DATA_W'(c.direction_mask));
    cfg_we <= 1'b0;
    model.regs = c;
  endtask

  // mostly runs of one servo chasing one goal, with stray single words between them
  task automatic run_random(input int n_words);
    int                 sent, run_len;
    logic [2:0]         idx;
    logic signed [7:0]  pos, off;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(149) == 0) wait_drain();
      if ($urandom_range(99) < 75) begin
        idx     = 3'($urandom_range(NUM_SERVOS - 1));
        pos     = pick_angle();
        off     = pick_angle();
        run_len = $urandom_range(1, 40);
        repeat (run_len) begin
          send_word(mk(idx, pos, pick_speed(), off));
          sent++;
        end
      end else begin
        send_word(in_word_t'(IN_W'($urandom)));
        sent++;
      end
    end
  endtask

  initial begin
    cfg_t plan [8];
    plan[0] = cfg_t'{16'd0, 8'd255, 16'd65535, 8'h00};
    plan[1] = cfg_t'{16'd65535, 8'd255, 16'd65535, 8'h3C};
    plan[2] = cfg_t'{16'd30000, 8'd142, 16'd1000, 8'h00};
    plan[3] = cfg_t'{16'($urandom), 8'($urandom), 16'($urandom), 8'($urandom)};
    plan[4] = cfg_t'{16'd0, 8'd255, 16'd65535, 8'hFF};
    plan[5] = cfg_t'{16'($urandom), 8'($urandom), 16'($urandom_range(300)), 8'($urandom)};
    plan[6] = cfg_t'{16'd1500, 8'd200, 16'd800, 8'h55};
    plan[7] = cfg_t'{16'd30000, 8'd142, 16'd1000, 8'h00};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: lock at neutral, zero speed, speed-limited moves both ways
    send_word(mk(3'd0, 8'sd0, 8'd0, 8'sd0));
    send_word(mk(3'd1, 8'sd127, 8'd0, 8'sd0));
    send_word(mk(3'd1, 8'sd127, 8'd255, 8'sd127));
    send_word(mk(3'd2, -8'sd128, 8'd255, -8'sd128));
    send_word(mk(3'd3, 8'sd5, 8'd255, 8'sd0));
    send_word(mk(3'd4, 8'sd10, 8'd255, 8'sd0));
    send_word(mk(3'd4, 8'sd10, 8'd255, 8'sd0));
    send_word(mk(3'd5, -8'sd5, 8'd50, 8'sd5));
    send_word(mk(3'd7, 8'sd1, 8'd1, 8'sd0));
    send_word(mk(3'd6, 8'sd0, 8'd255, 8'sd0));

    // zero slew limit: only an exact match locks
    write_config(cfg_t'{16'd30000, 8'd255, 16'd0, 8'hAA});
    send_word(mk(3'd0, 8'sd0, 8'd255, 8'sd0));
    send_word(mk(3'd1, 8'sd1, 8'd255, 8'sd0));
    send_word(mk(3'd3, -8'sd1, 8'd255, 8'sd0));

    // all servos inverted, goals beyond 16 bits
    write_config(cfg_t'{16'd65535, 8'd255, 16'd65535, 8'hFF});
    send_word(mk(3'd2, 8'sd127, 8'd255, 8'sd127));
    send_word(mk(3'd0, -8'sd128, 8'd255, -8'sd128));
    send_word(mk(3'd7, 8'sd127, 8'd255, -8'sd128));

    // zero gain: goal is neutral, step is zero
    write_config(cfg_t'{16'd0, 8'd0, 16'd500, 8'h0F});
    send_word(mk(3'd5, 8'sd127, 8'd255, 8'sd127));
    send_word(mk(3'd6, -8'sd128, 8'd0, 8'sd0));

    write_config(cfg_t'{16'd12345, 8'd1, 16'd3, 8'h00});
    send_word(mk(3'd4, 8'sd100, 8'd255, 8'sd20));
    send_word(mk(3'd0, 8'sd0, 8'd0, 8'sd0));

    for (int p = 0; p < 8; p++) begin
      write_config(plan[p]);
      case (p % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 72;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 72;
        end
        default: begin
          idle_pct  = 10;
          stall_pct = 10;
        end
      endcase
      run_random(PHASE_WORDS);
    end

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (model.pending() != 0)
      report_mismatch($sformatf(" %0d words never arrived", model.pending()));
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- servo_pulse_slew_limiter.f -----
+incdir+rtl/core
rtl/core/spl_pkg.sv
rtl/core/spl_cfg.sv
rtl/core/spl_calc.sv
rtl/core/spl_track.sv
rtl/core/servo_pulse_slew_limiter.sv
rtl/core/spl_check.sv
sim/tb.sv
